FILE: rtl/frst_pkg.sv
package frst_pkg;

	localparam int SLOTS  = 4;
	localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	localparam int ID_W    = 31;
	localparam int CNT_W   = 16;
	localparam int OFF_W   = 24;
	localparam int FLEN_W  = 16;
	localparam int MLEN_W  = 24;
	localparam int SLOTO_W = 2;

	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

	// queue between front and back; depth is a power of two
	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	typedef struct packed {
		logic [ID_W-1:0]   message_id;
		logic [CNT_W-1:0]  fragments_in_message;
		logic [OFF_W-1:0]  fragment_offset;
		logic [FLEN_W-1:0] fragment_length;
		logic [MLEN_W-1:0] message_length;
	} in_item_t;

	typedef struct packed {
		logic [SLOTO_W-1:0] slot;
		logic [OFF_W-1:0]   write_offset;
		logic [FLEN_W-1:0]  write_length;
		logic               evicted;
		logic [ID_W-1:0]    evicted_id;
		logic               complete;
		logic [MLEN_W-1:0]  done_length;
	} out_item_t;

	// queue head as seen by the back end
	typedef struct packed {
		logic     valid;
		in_item_t item;
	} q_head_t;

endpackage

FILE: rtl/frst_front.sv
module frst_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              frag_valid,
	output logic              frag_ready,
	input  frst_pkg::in_item_t frag,
	output frst_pkg::q_head_t head,
	input  logic              pop
);
	import frst_pkg::*;

	in_item_t          buf_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              push;
	logic              do_pop;

	assign frag_ready = (count_q != QCNT_W'(QDEPTH));
	assign push       = frag_valid && frag_ready;
	assign do_pop     = pop && (count_q != '0);

	assign head.valid = (count_q != '0);
	assign head.item  = buf_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_ptr_q] <= frag;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			unique case ({push, do_pop})
				2'b10:   count_q <= count_q + QCNT_W'(1);
				2'b01:   count_q <= count_q - QCNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

FILE: rtl/frst_back.sv
module frst_back (
	input  logic               clk,
	input  logic               arst_n,
	input  frst_pkg::q_head_t  head,
	output logic               pop,
	output logic               res_valid,
	input  logic               res_ready,
	output frst_pkg::out_item_t res
);
	import frst_pkg::*;

	logic              busy_q [SLOTS];
	logic [ID_W-1:0]   id_q   [SLOTS];
	logic [CNT_W-1:0]  seen_q [SLOTS];
	logic [CNT_W-1:0]  exp_q  [SLOTS];
	logic [MLEN_W-1:0] len_q  [SLOTS];

	logic              out_valid_q;
	out_item_t         out_q;

	logic              advance;
	logic              hit;
	logic [SLOT_W-1:0] hit_idx;
	logic              free_found;
	logic [SLOT_W-1:0] free_idx;
	logic [SLOT_W-1:0] vic_idx;
	logic [ID_W-1:0]   vic_id;
	logic [SLOT_W-1:0] sel;
	logic              evict;
	logic [CNT_W-1:0]  seen_base;
	logic [CNT_W-1:0]  seen_new;
	logic [CNT_W-1:0]  exp_sel;
	logic [MLEN_W-1:0] len_sel;
	logic              done;
	logic [31:0]       sel_ext;
	out_item_t         result;

	assign advance = head.valid && (!out_valid_q || res_ready);
	assign pop     = advance;

	// lowest index wins both searches
	always_comb begin
		hit        = 1'b0;
		hit_idx    = '0;
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (busy_q[i] && (id_q[i] == head.item.message_id)) begin
				hit     = 1'b1;
				hit_idx = SLOT_W'(i);
			end
			if (!busy_q[i]) begin
				free_found = 1'b1;
				free_idx   = SLOT_W'(i);
			end
		end
	end

	// smallest stored id; only used when every slot is busy
	always_comb begin
		vic_idx = '0;
		vic_id  = id_q[0];
		for (int i = 1; i < SLOTS; i++) begin
			if (id_q[i] < vic_id) begin
				vic_idx = SLOT_W'(i);
				vic_id  = id_q[i];
			end
		end
	end

	always_comb begin
		evict = !hit && !free_found;
		priority if (hit) begin
			sel = hit_idx;
		end else if (free_found) begin
			sel = free_idx;
		end else begin
			sel = vic_idx;
		end
		seen_base = hit ? seen_q[sel] : '0;
		seen_new  = (seen_base != CNT_MAX) ? seen_base + CNT_W'(1) : seen_base;
		exp_sel   = hit ? exp_q[sel] : head.item.fragments_in_message;
		len_sel   = hit ? len_q[sel] : head.item.message_length;
		done      = (seen_new >= exp_sel);
		sel_ext   = 32'(sel);

		result.slot         = sel_ext[SLOTO_W-1:0];
		result.write_offset = head.item.fragment_offset;
		result.write_length = head.item.fragment_length;
		result.evicted      = evict;
		result.evicted_id   = evict ? vic_id : '0;
		result.complete     = done;
		result.done_length  = done ? len_sel : '0;
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			seen_q[sel] <= seen_new;
			if (!hit) begin
				id_q[sel]  <= head.item.message_id;
				exp_q[sel] <= head.item.fragments_in_message;
				len_q[sel] <= head.item.message_length;
			end
			out_q <= result;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				busy_q[i] <= 1'b0;
			end
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				busy_q[sel] <= !done;
				out_valid_q <= 1'b1;
			end else if (res_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign res_valid = out_valid_q;
	assign res       = out_q;

endmodule

FILE: rtl/fragment_reassembly_slot_table_top.sv
// Fragment reassembly slot table.
// Input channel (frag_valid / frag_ready / frag): one decoded fragment header
// per beat. Output channel (res_valid / res_ready / res): one result beat per
// input beat, in order: slot, write offset and length for the payload buffer,
// eviction flag and id, completion flag and stored message length.
// A two-entry queue takes header beats; the back end pops one header per
// cycle while the result register can advance, matches its id against all
// slots in parallel, picks a free slot or evicts the smallest id, updates
// the slot counters and loads the result register in the same cycle.
// Path: an accepted header is written into the queue, then popped into the
// result register, which drives its result beat.
// Throughput: one beat per cycle while the receiver takes beats, set by the
// combinational slot lookup and the slot update in the back end.
// Receiver stall: hold the result register; the queue fills, and frag_ready
// drops once both queue entries hold headers.
// Reset: all slots free, queue empty, no result pending. Slot contents need
// no clearing pass; a slot is read only while marked busy.
module fragment_reassembly_slot_table_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                frag_valid,
	output logic                frag_ready,
	input  frst_pkg::in_item_t  frag,
	output logic                res_valid,
	input  logic                res_ready,
	output frst_pkg::out_item_t res
);
	import frst_pkg::*;

	q_head_t head;
	logic    pop;

	// front: take header beats into the queue
	frst_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.frag_valid(frag_valid),
		.frag_ready(frag_ready),
		.frag      (frag),
		.head      (head),
		.pop       (pop)
	);

	// back: look up, allocate or evict, count, and register the result
	frst_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.pop      (pop),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res      (res)
	);

endmodule

FILE: rtl/frst_checker.sv
module frst_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                res_valid,
	input logic                res_ready,
	input frst_pkg::out_item_t res
);
	import frst_pkg::*;

	// a stalled result beat holds its payload
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res))
		else $error("result beat changed while stalled");

	// no eviction reports a zero id
	a_evict_id: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res.evicted |-> res.evicted_id == '0)
		else $error("evicted id set without eviction");

	// an incomplete message reports a zero length
	a_done_len: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res.complete |-> res.done_length == '0)
		else $error("done length set without completion");

endmodule

bind fragment_reassembly_slot_table_top frst_checker u_frst_checker (.*);

FILE: tb/sv/tb.sv
module tb;
	import frst_pkg::*;

	localparam int HALF_PERIOD  = 10;
	localparam int RESET_CYCLES = 7;
	localparam int RANDOM_ITEMS = 1650;
	localparam int STALL_MAX    = 16;
	// Long receiver hold-off: start it after this many result beats.
	localparam int HOLD_AT      = 500;
	localparam int HOLD_CYCLES  = 300;
	// Sender pause: drain every pending result before this random item.
	localparam int PAUSE_AT     = 800;
	// Cycles with no beat on either channel before the run is called hung.
	localparam int HANG_LIMIT   = 3000;
	// Drain tail after the last result.
	localparam int TAIL_CYCLES  = 8;
	localparam int STREAMS      = 6;

	localparam logic [ID_W-1:0]   ID_MAX   = {ID_W{1'b1}};
	localparam logic [OFF_W-1:0]  OFF_MAX  = {OFF_W{1'b1}};
	localparam logic [FLEN_W-1:0] FLEN_MAX = {FLEN_W{1'b1}};
	localparam logic [MLEN_W-1:0] MLEN_MAX = {MLEN_W{1'b1}};

	// One directed row: a header, and optionally a result typed in by hand.
	typedef struct packed {
		in_item_t  hdr;
		logic      typed;
		out_item_t want;
	} frag_row_t;

	logic      clk = 1'b0;
	logic      arst_n;
	logic      frag_valid;
	logic      frag_ready;
	in_item_t  frag;
	logic      res_valid;
	logic      res_ready;
	out_item_t res;

	fragment_reassembly_slot_table_top uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.frag_valid (frag_valid),
		.frag_ready (frag_ready),
		.frag       (frag),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res        (res)
	);

	always #HALF_PERIOD clk = ~clk;

	// Mirror of the slot table, updated once per accepted header beat.
	logic              tbl_busy  [SLOTS];
	logic [ID_W-1:0]   tbl_id    [SLOTS];
	logic [CNT_W-1:0]  tbl_seen  [SLOTS];
	logic [CNT_W-1:0]  tbl_total [SLOTS];
	logic [MLEN_W-1:0] tbl_len   [SLOTS];

	// Results predicted for accepted headers, oldest first.
	out_item_t pending_placements[$];

	int  errors = 0;
	// Set per phase; when high neither side adds random idle gaps.
	bit  quiet  = 1'b0;

	// Live messages that the random generator walks fragment by fragment.
	logic [ID_W-1:0]   str_id    [STREAMS];
	logic [CNT_W-1:0]  str_total [STREAMS];
	logic [FLEN_W-1:0] str_chunk [STREAMS];
	logic [MLEN_W-1:0] str_len   [STREAMS];
	int                str_sent  [STREAMS];
	int                str_n = 0;

	frag_row_t directed_rows[$];

	task automatic flag_error(input string msg);
		$display("mismatch at %0t: %s", $time, msg);
		errors++;
	endtask

	function automatic in_item_t make_hdr(input logic [ID_W-1:0] id,
			input logic [CNT_W-1:0] total, input logic [OFF_W-1:0] off,
			input logic [FLEN_W-1:0] len, input logic [MLEN_W-1:0] mlen);
		in_item_t h;
		h.message_id           = id;
		h.fragments_in_message = total;
		h.fragment_offset      = off;
		h.fragment_length      = len;
		h.message_length       = mlen;
		return h;
	endfunction

	function automatic out_item_t make_res(input int s, input logic [OFF_W-1:0] off,
			input logic [FLEN_W-1:0] len, input logic ev, input logic [ID_W-1:0] ev_id,
			input logic done, input logic [MLEN_W-1:0] done_len);
		out_item_t r;
		r.slot         = SLOTO_W'(s);
		r.write_offset = off;
		r.write_length = len;
		r.evicted      = ev;
		r.evicted_id   = ev_id;
		r.complete     = done;
		r.done_length  = done_len;
		return r;
	endfunction

	// Place one header: hit, else first free slot, else evict the smallest id.
	function automatic out_item_t place_fragment(input in_item_t h);
		out_item_t r;
		int        s;
		int        i;
		r = '0;
		s = -1;
		for (i = 0; i < SLOTS; i++)
			if (s < 0 && tbl_busy[i] && tbl_id[i] == h.message_id)
				s = i;
		if (s < 0) begin
			for (i = 0; i < SLOTS; i++)
				if (s < 0 && !tbl_busy[i])
					s = i;
			if (s < 0) begin
				s = 0;
				for (i = 1; i < SLOTS; i++)
					if (tbl_id[i] < tbl_id[s])
						s = i;
				r.evicted    = 1'b1;
				r.evicted_id = tbl_id[s];
			end
			tbl_busy[s]  = 1'b1;
			tbl_id[s]    = h.message_id;
			tbl_total[s] = h.fragments_in_message;
			tbl_seen[s]  = '0;
			tbl_len[s]   = h.message_length;
		end
		if (tbl_seen[s] != CNT_MAX)
			tbl_seen[s]++;
		if (tbl_seen[s] >= tbl_total[s]) begin
			r.complete    = 1'b1;
			r.done_length = tbl_len[s];
			tbl_busy[s]   = 1'b0;
		end
		r.slot         = SLOTO_W'(s);
		r.write_offset = h.fragment_offset;
		r.write_length = h.fragment_length;
		return r;
	endfunction

	function automatic int idle_gap();
		return quiet ? 0 : $urandom_range(0, STALL_MAX);
	endfunction

	// Mostly fragments of live messages in random interleave; the rest noise.
	function automatic in_item_t next_header();
		in_item_t h;
		int       pick;
		int       k;
		pick = $urandom_range(0, 9);
		if (pick < 2) begin
			// Noise: a live id with a clashing header, or any bits at all.
			if (pick == 1 && str_n > 0) begin
				k = $urandom_range(0, str_n - 1);
				h = make_hdr(str_id[k], CNT_W'($urandom), OFF_W'($urandom),
					FLEN_W'($urandom), MLEN_W'($urandom));
			end else begin
				h = make_hdr(ID_W'($urandom), CNT_W'($urandom), OFF_W'($urandom),
					FLEN_W'($urandom), MLEN_W'($urandom));
			end
			return h;
		end
		if (str_n == 0 || (str_n < STREAMS && $urandom_range(0, 3) == 0)) begin
			k = str_n;
			str_id[k]    = ($urandom_range(0, 3) == 0) ? ID_W'($urandom)
			                                           : ID_W'($urandom_range(0, 40));
			str_total[k] = ($urandom_range(0, 7) == 0) ? '0 : CNT_W'($urandom_range(1, 8));
			str_chunk[k] = FLEN_W'($urandom_range(1, 1500));
			str_len[k]   = MLEN_W'(str_total[k] * str_chunk[k]);
			str_sent[k]  = 0;
			str_n++;
		end
		k = $urandom_range(0, str_n - 1);
		h = make_hdr(str_id[k], str_total[k], OFF_W'(str_sent[k] * str_chunk[k]),
			str_chunk[k], str_len[k]);
		str_sent[k]++;
		if (str_sent[k] >= str_total[k]) begin
			// Retire the message; move the last live one into its place.
			str_n--;
			str_id[k]    = str_id[str_n];
			str_total[k] = str_total[str_n];
			str_chunk[k] = str_chunk[str_n];
			str_len[k]   = str_len[str_n];
			str_sent[k]  = str_sent[str_n];
		end
		return h;
	endfunction

	// Offer one header beat after a random gap, then predict at acceptance.
	// Keep valid high through a zero gap so it is never dropped and raised
	// in the same step.
	task automatic offer_header(input in_item_t h, input logic typed,
			input out_item_t want);
		int        gap;
		out_item_t predicted;
		gap = idle_gap();
		if (gap > 0) begin
			frag_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		frag       <= h;
		frag_valid <= 1'b1;
		do @(posedge clk); while (!frag_ready);
		predicted = place_fragment(h);
		pending_placements.push_back(typed ? want : predicted);
	endtask

	// Compare one result beat against the oldest prediction, field by field.
	task automatic compare_result(input out_item_t got);
		out_item_t   want;
		logic [31:0] g;
		logic [31:0] w;
		string       nm;
		int          i;
		if (pending_placements.size() == 0) begin
			flag_error("result beat with no header pending");
			return;
		end
		want = pending_placements.pop_front();
		for (i = 0; i < 7; i++) begin
			case (i)
				0: begin
					nm = "slot";
					g  = 32'(got.slot);
					w  = 32'(want.slot);
				end
				1: begin
					nm = "write_offset";
					g  = 32'(got.write_offset);
					w  = 32'(want.write_offset);
				end
				2: begin
					nm = "write_length";
					g  = 32'(got.write_length);
					w  = 32'(want.write_length);
				end
				3: begin
					nm = "evicted";
					g  = 32'(got.evicted);
					w  = 32'(want.evicted);
				end
				4: begin
					nm = "evicted_id";
					g  = 32'(got.evicted_id);
					w  = 32'(want.evicted_id);
				end
				5: begin
					nm = "complete";
					g  = 32'(got.complete);
					w  = 32'(want.complete);
				end
				default: begin
					nm = "done_length";
					g  = 32'(got.done_length);
					w  = 32'(want.done_length);
				end
			endcase
			if (g !== w)
				flag_error($sformatf("%s got 0x%0h want 0x%0h", nm, g, w));
		end
	endtask

	task automatic add_row(input in_item_t h, input logic typed, input out_item_t want);
		frag_row_t r;
		r.hdr   = h;
		r.typed = typed;
		r.want  = want;
		directed_rows.push_back(r);
	endtask

	// Directed headers. The table starts empty, so the early rows and the
	// eviction points can be read off by hand.
	task automatic build_directed();
		// Single-fragment message right after reset: slot 0, done at once.
		add_row(make_hdr(5, 1, 0, 0, 100), 1'b1, make_res(0, 0, 0, 0, 0, 1, 100));
		// All-ones fields and a zero fragment total: completes on first beat.
		add_row(make_hdr(ID_MAX, 0, OFF_MAX, FLEN_MAX, MLEN_MAX), 1'b1,
			make_res(0, OFF_MAX, FLEN_MAX, 0, 0, 1, MLEN_MAX));
		add_row(make_hdr(0, 3, 10, 20, 50), 1'b1, make_res(0, 10, 20, 0, 0, 0, 0));
		// Hit with a differing header: total and length are ignored.
		add_row(make_hdr(0, 9, 30, 20, 999), 1'b0, '0);
		// Duplicate fragment counts again and completes with the stored length.
		add_row(make_hdr(0, 1, 30, 20, 7), 1'b1, make_res(0, 30, 20, 0, 0, 1, 50));
		// Fill all four slots.
		add_row(make_hdr(300, 5, 0, 100, 500), 1'b0, '0);
		add_row(make_hdr(100, 5, 0, 100, 500), 1'b0, '0);
		add_row(make_hdr(400, 5, 0, 100, 500), 1'b0, '0);
		add_row(make_hdr(200, 5, 0, 100, 500), 1'b0, '0);
		// Table full: evict the smallest id (100 in slot 1).
		add_row(make_hdr(50, 2, 0, 64, 128), 1'b1, make_res(1, 0, 64, 1, 100, 0, 0));
		add_row(make_hdr(ID_MAX, 2, 0, 64, 128), 1'b0, '0);
		// Evict id 200 from slot 3 and complete in the same beat.
		add_row(make_hdr(0, 1, 0, 8, 8), 1'b1, make_res(3, 0, 8, 1, 200, 1, 8));
		add_row(make_hdr(1, 1, 4, 4, 4), 1'b1, make_res(3, 4, 4, 0, 0, 1, 4));
		add_row(make_hdr(300, 0, OFF_MAX, FLEN_MAX, 0), 1'b0, '0);
		add_row(make_hdr(300, 5, 100, 100, 500), 1'b0, '0);
		add_row(make_hdr(300, 5, 200, 100, 500), 1'b0, '0);
		add_row(make_hdr(300, 5, 400, 100, 500), 1'b0, '0);
		add_row(make_hdr(400, 0, 100, 100, 1), 1'b0, '0);
		add_row(make_hdr(12345, CNT_MAX, OFF_MAX, 0, MLEN_MAX), 1'b0, '0);
		add_row(make_hdr(ID_MAX, 2, 64, 64, 128), 1'b0, '0);
		// Out-of-bounds fragment: offset and length pass through.
		add_row(make_hdr(77, 1, OFF_MAX, FLEN_MAX, 16), 1'b0, '0);
	endtask

	// Sender: reset, directed rows, random headers, then drain and judge.
	initial begin
		int i;
		arst_n     = 1'b0;
		frag_valid = 1'b0;
		frag       = '0;
		res_ready  = 1'b0;
		for (i = 0; i < SLOTS; i++) begin
			tbl_busy[i]  = 1'b0;
			tbl_id[i]    = '0;
			tbl_seen[i]  = '0;
			tbl_total[i] = '0;
			tbl_len[i]   = '0;
		end
		build_directed();
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[j])
			offer_header(directed_rows[j].hdr, directed_rows[j].typed,
				directed_rows[j].want);

		for (i = 0; i < RANDOM_ITEMS; i++) begin
			// Pick a new idling mode every hundred beats.
			if (i % 100 == 0)
				quiet = ($urandom_range(0, 3) == 0);
			if (i == PAUSE_AT) begin
				// Hold off until every pending result has come back.
				frag_valid <= 1'b0;
				do @(posedge clk); while (pending_placements.size() != 0);
			end
			offer_header(next_header(), 1'b0, '0);
		end
		frag_valid <= 1'b0;

		while (pending_placements.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

	// Receiver: stall at random per beat, with one long hold-off that fills
	// the block's queue and drops frag_ready while the sender keeps offering.
	initial begin
		int taken;
		int w;
		bit held;
		taken = 0;
		held  = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (!held && taken == HOLD_AT) begin
				held = 1'b1;
				res_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				w = idle_gap();
				if (w > 0) begin
					res_ready <= 1'b0;
					repeat (w) @(posedge clk);
				end
			end
			res_ready <= 1'b1;
			do @(posedge clk); while (!res_valid);
			taken++;
			compare_result(res);
		end
	end

	// Watchdog: end the run if no beat moves on either channel for too long.
	initial begin
		int idle;
		idle = 0;
		wait (arst_n === 1'b1);
		while (idle < HANG_LIMIT) begin
			@(posedge clk);
			if ((frag_valid && frag_ready) || (res_valid && res_ready))
				idle = 0;
			else
				idle++;
		end
		$display("tb NOT OK");
		$finish;
	end

endmodule
